// File: rtl/hspd_pkg.sv
`default_nettype none

package hspd_pkg;

  localparam int unsigned FRAME_BITS            = 40;
  localparam int unsigned FRAME_BYTES           = 5;
  localparam int unsigned FIRST_DATA_TRANSITION = 4;
  localparam int unsigned MAX_TRANSITIONS       = 85;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic CFG_BIT_THRESHOLD = 1'b0;
  localparam logic CFG_TIMEOUT_POLLS = 1'b1;

  localparam logic [7:0] BIT_THRESHOLD_RESET = 8'd16;
  localparam logic [7:0] TIMEOUT_POLLS_RESET = 8'd255;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    frame_t     frame;
    logic [5:0] bits;
  } report_t;

endpackage

`default_nettype wire

// File: rtl/humidity_sensor_pulse_decoder.sv
`default_nettype none

// Receiver for the single-wire temperature and humidity sensor. A word with
// cmd 0 arms a read; each following word with cmd 1 carries one poll of the
// data line. Pulse widths are counted in polls and every second pulse from
// the fourth transition on is decoded into one data bit (one when its count
// exceeds bit_threshold). A read ends after 85 transitions or when one level
// lasts timeout_polls polls, and then one result word follows carrying the
// humidity, Celsius and Fahrenheit tenths, the bit count and the checksum
// verdict. One word is accepted every clock cycle. The result word passes
// three register stages: the report snapshot, the checksum and Celsius stage,
// and the output register behind the divide-by-five multiply. Input stalls
// only when the receiver holds off and three result words are waiting.
module humidity_sensor_pulse_decoder
  import hspd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               cmd_i,
  input  wire logic               line_level_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    reading_valid_o,
  output logic                    checksum_ok_o,
  output logic [5:0]              bits_received_o,
  output logic [15:0]             humidity_tenths_o,
  output logic signed [15:0]      temp_tenths_c_o,
  output logic signed [16:0]      temp_tenths_f_o
);

  logic [7:0] thr_q, tmo_q;
  logic       last_q, last_d;
  logic [7:0] poll_q, poll_d;
  logic [6:0] trans_q, trans_d;
  logic [5:0] bit_idx_q, bit_idx_d;
  frame_t     frame_q, frame_d;
  logic       done_q, done_d;
  logic       rep_v_q;
  report_t    rep_q;
  logic       rep_ready;
  logic       in_accept, end_read, take_bit, bit_val;
  logic [7:0] poll_inc;
  logic [6:0] trans_inc;
  logic [2:0] byte_sel;

  assign in_ready_o = !rep_v_q || rep_ready;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    last_d    = last_q;
    poll_d    = poll_q;
    trans_d   = trans_q;
    bit_idx_d = bit_idx_q;
    frame_d   = frame_q;
    done_d    = done_q;
    end_read  = 1'b0;
    poll_inc  = (poll_q == 8'hFF) ? 8'hFF : poll_q + 8'd1;
    trans_inc = trans_q + 7'd1;
    byte_sel  = bit_idx_q[5:3];
    bit_val   = (poll_q > thr_q);
    take_bit  = (trans_q >= 7'(FIRST_DATA_TRANSITION)) && !trans_q[0]
             && (bit_idx_q < 6'(FRAME_BITS));
    if (in_accept) begin
      if (cmd_i == CMD_START) begin
        last_d    = 1'b1;
        poll_d    = '0;
        trans_d   = '0;
        bit_idx_d = '0;
        frame_d   = '0;
        done_d    = 1'b0;
      end else if (!done_q) begin
        if (line_level_i == last_q) begin
          poll_d   = poll_inc;
          end_read = (poll_inc >= tmo_q);
        end else begin
          // The count just finished belongs to the pulse that has ended.
          if (take_bit) begin
            for (int i = 0; i < FRAME_BYTES; i++) begin
              if (byte_sel == 3'(i)) begin
                frame_d[i] = {frame_q[i][6:0], bit_val};
              end
            end
            bit_idx_d = bit_idx_q + 6'd1;
          end
          trans_d  = trans_inc;
          poll_d   = '0;
          last_d   = line_level_i;
          end_read = (trans_inc >= 7'(MAX_TRANSITIONS));
        end
      end
    end
    if (end_read) begin
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= BIT_THRESHOLD_RESET;
      tmo_q     <= TIMEOUT_POLLS_RESET;
      last_q    <= 1'b1;
      poll_q    <= '0;
      trans_q   <= '0;
      bit_idx_q <= '0;
      frame_q   <= '0;
      done_q    <= 1'b1;
      rep_v_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BIT_THRESHOLD: thr_q <= cfg_data_i;
          CFG_TIMEOUT_POLLS: tmo_q <= cfg_data_i;
          default:           thr_q <= thr_q;
        endcase
      end
      last_q    <= last_d;
      poll_q    <= poll_d;
      trans_q   <= trans_d;
      bit_idx_q <= bit_idx_d;
      frame_q   <= frame_d;
      done_q    <= done_d;
      if (end_read) begin
        rep_v_q <= 1'b1;
      end else if (rep_ready) begin
        rep_v_q <= 1'b0;
      end
    end
  end

  // The report snapshot takes the frame as it stands after this word.
  always_ff @(posedge clk_i) begin
    if (end_read) begin
      rep_q.frame <= frame_d;
      rep_q.bits  <= bit_idx_d;
    end
  end

  hspd_report u_report (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rep_valid_i       (rep_v_q),
    .rep_ready_o       (rep_ready),
    .rep_i             (rep_q),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .reading_valid_o   (reading_valid_o),
    .checksum_ok_o     (checksum_ok_o),
    .bits_received_o   (bits_received_o),
    .humidity_tenths_o (humidity_tenths_o),
    .temp_tenths_c_o   (temp_tenths_c_o),
    .temp_tenths_f_o   (temp_tenths_f_o)
  );

endmodule

`default_nettype wire

// File: rtl/hspd_report.sv
`default_nettype none

module hspd_report
  import hspd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               rep_valid_i,
  output logic                    rep_ready_o,
  input  wire report_t            rep_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    reading_valid_o,
  output logic                    checksum_ok_o,
  output logic [5:0]              bits_received_o,
  output logic [15:0]             humidity_tenths_o,
  output logic signed [15:0]      temp_tenths_c_o,
  output logic signed [16:0]      temp_tenths_f_o
);

  // ceil(2^21 / 5); exact for dividends below 2^21 / 3.
  localparam logic [18:0] RECIP_FIVE = 19'd419431;

  logic        b_v_q;
  logic        b_ok_q, b_ok_d;
  logic [5:0]  b_bits_q;
  logic [15:0] b_hum_q, b_hum_d;
  logic signed [15:0] b_c_q, b_c_d;
  logic        b_neg_q, b_neg_d;
  logic [18:0] b_abs_q, b_abs_d;

  logic        c_ready, b_ready;
  logic [9:0]  sum;
  logic [15:0] mag;
  logic signed [19:0] c_ext, num;
  logic [37:0] prod;
  logic [16:0] quot, f_d;

  assign c_ready     = !out_valid_o || out_ready_i;
  assign b_ready     = !b_v_q || c_ready;
  assign rep_ready_o = b_ready;

  always_comb begin
    sum = 10'(rep_i.frame[0]) + 10'(rep_i.frame[1]) + 10'(rep_i.frame[2])
        + 10'(rep_i.frame[3]);
    b_ok_d  = (sum[7:0] == rep_i.frame[4]);
    b_hum_d = {rep_i.frame[0], rep_i.frame[1]};
    mag     = {1'b0, rep_i.frame[2][6:0], rep_i.frame[3]};
    b_c_d   = rep_i.frame[2][7] ? -$signed(mag) : $signed(mag);
    c_ext   = 20'(b_c_d);
    num     = (c_ext <<< 3) + c_ext + 20'sd1600;
    b_neg_d = num[19];
    b_abs_d = b_neg_d ? 19'(-num) : num[18:0];
  end

  always_comb begin
    prod = 38'(b_abs_q) * 38'(RECIP_FIVE);
    quot = prod[37:21];
    f_d  = b_neg_q ? -quot : quot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q       <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (b_ready) begin
        b_v_q <= rep_valid_i;
      end
      if (c_ready) begin
        out_valid_o <= b_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && rep_valid_i) begin
      b_ok_q   <= b_ok_d;
      b_bits_q <= rep_i.bits;
      b_hum_q  <= b_hum_d;
      b_c_q    <= b_c_d;
      b_neg_q  <= b_neg_d;
      b_abs_q  <= b_abs_d;
    end
    if (c_ready && b_v_q) begin
      reading_valid_o   <= b_ok_q && (b_bits_q >= 6'(FRAME_BITS));
      checksum_ok_o     <= b_ok_q;
      bits_received_o   <= b_bits_q;
      humidity_tenths_o <= b_hum_q;
      temp_tenths_c_o   <= b_c_q;
      temp_tenths_f_o   <= $signed(f_d);
    end
  end

endmodule

`default_nettype wire
